/* src/ilist_pkg.sv */
package ilist_pkg;

  localparam int Capacity = 16;
  localparam int SlotW    = $clog2(Capacity);
  localparam int CountW   = 5;
  localparam int PosW     = 5;
  localparam int WordW    = 32;
  localparam int OpW      = 3;
  localparam int StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_DELETE    = 3'd2,
    OP_READ      = 3'd3,
    OP_DUMP      = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

/* src/ilist_if.sv */
interface ilist_in_if import ilist_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          opcode;
  logic signed [WordW-1:0] value;
  logic [PosW-1:0]         position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface ilist_out_if import ilist_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] word;
  logic [CountW-1:0]       count;
  logic [StatusW-1:0]      status;
  logic                    last;

  modport source (output valid, output word, output count, output status, output last,
                  input ready);
  modport sink   (input valid, input word, input count, input status, input last,
                  output ready);
endinterface

/* src/ilist_cell.sv */
module ilist_cell import ilist_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [WordW-1:0] value_i,
  input  logic signed [WordW-1:0] left_i,
  input  logic signed [WordW-1:0] right_i,
  output logic signed [WordW-1:0] data_o
);

  logic signed [WordW-1:0] data_d, data_q;

  always_comb begin
    unique case (ctrl_i.op)
      CELL_HOLD:       data_d = data_q;
      CELL_LOAD:       data_d = value_i;
      CELL_FROM_LEFT:  data_d = left_i;
      CELL_FROM_RIGHT: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* src/ilist_row.sv */
module ilist_row import ilist_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i [Capacity],
  input  logic signed [WordW-1:0] value_i,
  input  logic [SlotW-1:0]        rd_slot_i,
  output logic signed [WordW-1:0] rd_word_o,
  output logic signed [WordW-1:0] head_word_o
);

  logic signed [WordW-1:0] cell_data [Capacity];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    ilist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i[i]),
      .value_i (value_i),
      .left_i  (cell_data[(i + Capacity - 1) % Capacity]),
      .right_i (cell_data[(i + 1) % Capacity]),
      .data_o  (cell_data[i])
    );
  end

  assign rd_word_o   = cell_data[rd_slot_i];
  assign head_word_o = cell_data[0];

endmodule

/* src/indexed_list_engine_core.sv */
// Indexed list engine: ordered list of up to Capacity signed 32-bit words.
// Input channel in_i carries opcode, value and position; output channel out_o
// carries word, count, status and last. Both use valid/ready; an item moves
// when valid and ready are high at a rising clock edge.
// Add front/back, delete, read and clear give one result item, registered as
// the input item is taken; the list is updated in that same cycle
// by the row of cells (front insert and delete shift the row in one step).
// Dump rotates the cell ring one place per cycle unless held by a waiting result
// item, Capacity places in all, handing out the front cell as a result item in
// the first count of them.
// A new item is taken only while no dump is running and the output register
// is free or being emptied in the same cycle.
// While out_o.ready is low the result holds; during a dump the ring stops
// rotating while a result item waits and moves on once only idle turns remain.
// Reset empties the list; stored words are not cleared.
module indexed_list_engine_core import ilist_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ilist_in_if.sink      in_i,
  ilist_out_if.source   out_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [SlotW-1:0]        rot_q, rot_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [WordW-1:0] out_word_q, out_word_d;
  logic [CountW-1:0]       out_count_q, out_count_d;
  logic [StatusW-1:0]      out_status_q, out_status_d;
  logic                    out_last_q, out_last_d;

  cell_ctrl_t              cell_ctrl [Capacity];
  logic signed [WordW-1:0] rd_word, head_word;
  logic [SlotW-1:0]        rd_slot;
  logic [CountW-1:0]       del_lo;
  logic                    slot_free, in_take, pos_bad, full, emit;

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && slot_free;
  assign in_take = in_i.valid && in_i.ready;
  assign pos_bad = (in_i.position == '0) || (in_i.position > count_q);
  assign full = (count_q >= CountW'(Capacity));
  assign del_lo = in_i.position - CountW'(1);
  assign rd_slot = del_lo[SlotW-1:0];
  assign emit = ({{(CountW-SlotW){1'b0}}, rot_q} < count_q);

  ilist_row u_row (
    .clk_i       (clk_i),
    .ctrl_i      (cell_ctrl),
    .value_i     (in_i.value),
    .rd_slot_i   (rd_slot),
    .rd_word_o   (rd_word),
    .head_word_o (head_word)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rot_d        = rot_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_word_d   = out_word_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    for (int i = 0; i < Capacity; i++) begin
      cell_ctrl[i].op = CELL_HOLD;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          out_valid_d  = 1'b1;
          out_word_d   = '0;
          out_status_d = STAT_OK;
          out_last_d   = 1'b1;
          unique case (in_i.opcode)
            OP_ADD_FRONT: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                for (int i = 0; i < Capacity; i++) begin
                  cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                end
                count_d = count_q + CountW'(1);
              end
            end
            OP_ADD_BACK: begin
              if (full) begin
                out_status_d = STAT_FULL;
              end else begin
                for (int i = 0; i < Capacity; i++) begin
                  if (CountW'(i) == count_q) cell_ctrl[i].op = CELL_LOAD;
                end
                count_d = count_q + CountW'(1);
              end
            end
            OP_DELETE: begin
              if (pos_bad) begin
                out_status_d = STAT_BAD_INDEX;
              end else begin
                for (int i = 0; i < Capacity; i++) begin
                  if ((CountW'(i) >= del_lo) && (CountW'(i) + CountW'(1) < count_q)) begin
                    cell_ctrl[i].op = CELL_FROM_RIGHT;
                  end
                end
                count_d = count_q - CountW'(1);
              end
            end
            OP_READ: begin
              if (pos_bad) begin
                out_status_d = STAT_BAD_INDEX;
              end else begin
                out_word_d = rd_word;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                out_status_d = STAT_EMPTY;
              end else begin
                out_valid_d = out_valid_q && !out_o.ready;
                state_d     = ST_DUMP;
                rot_d       = '0;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
          out_count_d = count_d;
        end
      end
      ST_DUMP: begin
        if (!emit || slot_free) begin
          for (int i = 0; i < Capacity; i++) begin
            cell_ctrl[i].op = CELL_FROM_RIGHT;
          end
          if (emit) begin
            out_valid_d  = 1'b1;
            out_word_d   = head_word;
            out_count_d  = count_q;
            out_status_d = STAT_OK;
            out_last_d   = ({{(CountW-SlotW){1'b0}}, rot_q} + CountW'(1) == count_q);
          end
          if (rot_q == SlotW'(Capacity - 1)) begin
            state_d = ST_IDLE;
          end else begin
            rot_d = rot_q + SlotW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q   <= out_word_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.word   = out_word_q;
  assign out_o.count  = out_count_q;
  assign out_o.status = out_status_q;
  assign out_o.last   = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Capacity))
    else $error("element count above capacity");

  a_not_last_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> state_q == ST_DUMP)
    else $error("non-final result outside a dump");

  a_count_stable_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |=> $stable(count_q))
    else $error("count changed during dump");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == STAT_FULL |-> count_q == CountW'(Capacity))
    else $error("full status with free room");

endmodule
